/* src/fptc_pkg.sv */
// Shared types, codes and defaults for the flow permission table check.
`default_nettype none

package fptc_pkg;

  localparam int KEY_W     = 96;
  localparam int PERM_W    = 6;
  localparam int VERDICT_W = 3;
  localparam int HASH_W    = 32;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_PROBE_LIMIT   = 8;

  localparam logic [7:0] UDP_PROTO     = 8'd17;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  localparam logic [VERDICT_W-1:0] VERDICT_PASS_NON_UDP  = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_PASS_BAD_HDR  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_ALLOW         = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY_MISMATCH = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY_NO_ENTRY = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_INSERTED      = 3'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_OVERWRITTEN   = 3'd6;
  localparam logic [VERDICT_W-1:0] VERDICT_TABLE_FULL    = 3'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_WAIT,
    ST_DONE
  } fptc_state_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [PERM_W-1:0] perm;
  } entry_t;

  // Search state handed from probe cell to probe cell.
  typedef struct packed {
    logic              found;
    logic              free_found;
    logic [PERM_W-1:0] perm;
  } probe_stat_t;

endpackage

`default_nettype wire

/* src/fptc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/fptc_home.sv */
// Home slot of a flow key: XOR fold, then reduce modulo the table size.
`default_nettype none

module fptc_home import fptc_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [31:0]                      src_ip,
  input  wire logic [31:0]                      dst_ip,
  input  wire logic [15:0]                      src_port,
  input  wire logic [15:0]                      dst_port,
  output logic                                  done,
  output logic      [$clog2(TABLE_ENTRIES)-1:0] slot
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [HASH_W-1:0] fold;
  logic [HASH_W-1:0] h;

  assign fold = src_ip ^ dst_ip ^ {src_port, dst_port};
  assign h    = fold ^ {16'h0000, fold[31:16]};

  if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
    // Power-of-two table: the modulo is a mask.
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        slot <= h[AW-1:0];
      end
    end
  end else begin : g_recip
    // Other sizes: quotient by reciprocal multiplication, then subtract the
    // quotient times the table size.
    localparam logic [63:0] RECIP_FULL =
      ((64'd1 << (HASH_W + AW)) / 64'(TABLE_ENTRIES)) + 64'd1;
    localparam logic [HASH_W:0]   RECIP   = RECIP_FULL[HASH_W:0];
    localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(TABLE_ENTRIES);

    logic              stage1;
    logic              stage2;
    logic [HASH_W-1:0] h_q;
    logic [2*HASH_W:0] prod;
    logic [HASH_W-1:0] quo;
    logic [HASH_W-1:0] quo_mul;
    logic [HASH_W-1:0] rem;

    assign quo = HASH_W'(prod >> (HASH_W + AW));
    assign rem = h_q - quo_mul;

    always_ff @(posedge clk) begin
      if (rst) begin
        stage1 <= 1'b0;
        stage2 <= 1'b0;
        done   <= 1'b0;
      end else begin
        stage1 <= start;
        stage2 <= stage1;
        done   <= stage2;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        h_q  <= h;
        prod <= {{(HASH_W + 1){1'b0}}, h} * {{HASH_W{1'b0}}, RECIP};
      end
      if (stage1) begin
        quo_mul <= quo * DIVISOR;
      end
      if (stage2) begin
        slot <= rem[AW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* src/fptc_cell.sv */
// One probe cell: checks one table slot and hands the search state on.
`default_nettype none

module fptc_cell import fptc_pkg::*; #(
  parameter int AW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tok_in,
  input  wire probe_stat_t       stat_in,
  input  wire logic [AW-1:0]     hit_in,
  input  wire logic [AW-1:0]     free_in,
  input  wire entry_t            word,
  input  wire logic [AW-1:0]     word_slot,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   tok,
  output probe_stat_t            stat,
  output logic      [AW-1:0]     hit_slot,
  output logic      [AW-1:0]     free_slot
);

  probe_stat_t stat_next;
  logic [AW-1:0] hit_next;
  logic [AW-1:0] free_next;

  always_comb begin
    stat_next = stat_in;
    hit_next  = hit_in;
    free_next = free_in;
    if (!stat_in.found) begin
      if (word.valid && (word.key == key)) begin
        stat_next.found = 1'b1;
        stat_next.perm  = word.perm;
        hit_next        = word_slot;
      end else if (!word.valid && !stat_in.free_found) begin
        stat_next.free_found = 1'b1;
        free_next            = word_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  // Update only when the token passes; hold otherwise.
  always_ff @(posedge clk) begin
    if (tok_in) begin
      stat      <= stat_next;
      hit_slot  <= hit_next;
      free_slot <= free_next;
    end
  end

endmodule

`default_nettype wire

/* src/flow_permission_table_check_core.sv */
// Top level of the exact-match flow table with DSCP permission check.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/tready  | request: tuser = op, tdata = header fields + key
//  m_*     | out | m_tvalid/tready  | result: tdata = verdict, stored_permission
//
// Flow: a pass item (bad header or non-UDP) goes straight to its result. A probed
// item waits for the home slot (a mask on a power-of-two table, reciprocal multiply
// otherwise), then reads the one table read port once per probe slot and passes the
// words down the row of probe cells. One request is in work at a time.
// Reset: a clearing pass writes every slot, s_tready low.
// Stalls: a result waits in the output register while the next request is taken;
// a finished item holds in its last state until the output register is free.
`default_nettype none

module flow_permission_table_check_core import fptc_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int PROBE_LIMIT   = DEF_PROBE_LIMIT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [3:0] header_words, [11:4] protocol, [19:12] tos, [51:20] src_ip,
  // [83:52] dst_ip, [99:84] src_port, [115:100] dst_port, [121:116] new_permission
  input  wire logic [127:0] s_tdata,
  // [0] op
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [2:0] verdict, [8:3] stored_permission
  output logic      [15:0]  m_tdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(PROBE_LIMIT + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [AW:0] LAST_SLOT = (AW + 1)'(TABLE_ENTRIES - 1);

  // State machine
  fptc_state_t state;
  fptc_state_t state_next;

  // Held request fields
  logic              op_q;
  logic [3:0]        hdr_q;
  logic [7:0]        proto_q;
  logic [7:0]        tos_q;
  logic [KEY_W-1:0]  key_q;
  logic [PERM_W-1:0] perm_q;

  logic accept;
  logic need_probe;
  logic out_free;

  // Home slot unit
  logic          home_done;
  logic [AW-1:0] home_slot;

  // Probe sequencing
  logic [AW-1:0] paddr;
  logic [PW-1:0] pcnt;
  logic          rd_first;
  logic [AW-1:0] rd_slot;
  logic [AW:0]   clr_cnt;

  // Table RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_word;

  // Probe chain
  logic          tok      [PROBE_LIMIT];
  probe_stat_t   stat     [PROBE_LIMIT];
  logic [AW-1:0] hit_sl   [PROBE_LIMIT];
  logic [AW-1:0] free_sl  [PROBE_LIMIT];
  probe_stat_t   fin;

  // Result
  logic                 out_load;
  logic [VERDICT_W-1:0] verdict;
  logic [PERM_W-1:0]    stored;

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign need_probe = op_q || ((hdr_q >= MIN_HDR_WORDS) && (proto_q == UDP_PROTO));
  assign rd_word    = entry_t'(ram_rdata);
  assign fin        = stat[PROBE_LIMIT-1];

  // Latch the request on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= s_tuser;
      hdr_q   <= s_tdata[3:0];
      proto_q <= s_tdata[11:4];
      tos_q   <= s_tdata[19:12];
      key_q   <= s_tdata[115:20];
      perm_q  <= s_tdata[121:116];
    end
  end

  fptc_home #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_home (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .src_ip   (s_tdata[51:20]),
    .dst_ip   (s_tdata[83:52]),
    .src_port (s_tdata[99:84]),
    .dst_port (s_tdata[115:100]),
    .done     (home_done),
    .slot     (home_slot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (!need_probe) begin
          state_next = ST_DONE;
        end else if (home_done) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (pcnt == PW'(PROBE_LIMIT - 1)) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tok[PROBE_LIMIT-1]) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the state machine: RAM ports, ready, result load
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = paddr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt[AW-1:0];
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_PROBE: begin
        ram_re = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
        if (out_free && op_q && (fin.found || fin.free_found)) begin
          ram_we    = 1'b1;
          ram_waddr = fin.found ? hit_sl[PROBE_LIMIT-1] : free_sl[PROBE_LIMIT-1];
          ram_wdata = '{valid: 1'b1, key: key_q, perm: perm_q};
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Walk the probe window, wrapping at the table end.
  always_ff @(posedge clk) begin
    if (state == ST_HASH) begin
      paddr <= home_slot;
      pcnt  <= '0;
    end else if (state == ST_PROBE) begin
      paddr <= ({1'b0, paddr} == LAST_SLOT) ? '0 : paddr + 1'b1;
      pcnt  <= pcnt + 1'b1;
    end
  end

  // Tag read data with its slot; mark the first word of the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_first <= 1'b0;
    end else begin
      rd_first <= (state == ST_PROBE) && (pcnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= paddr;
  end

  fptc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (paddr),
    .rdata (ram_rdata)
  );

  // Row of probe cells: the token meets probe word k in cell k.
  for (genvar k = 0; k < PROBE_LIMIT; k++) begin : g_cell
    logic          tok_in;
    probe_stat_t   stat_in;
    logic [AW-1:0] hit_in;
    logic [AW-1:0] free_in;

    if (k == 0) begin : g_head
      assign tok_in  = rd_first;
      assign stat_in = '0;
      assign hit_in  = '0;
      assign free_in = '0;
    end else begin : g_link
      assign tok_in  = tok[k-1];
      assign stat_in = stat[k-1];
      assign hit_in  = hit_sl[k-1];
      assign free_in = free_sl[k-1];
    end

    fptc_cell #(
      .AW(AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok_in),
      .stat_in   (stat_in),
      .hit_in    (hit_in),
      .free_in   (free_in),
      .word      (rd_word),
      .word_slot (rd_slot),
      .key       (key_q),
      .tok       (tok[k]),
      .stat      (stat[k]),
      .hit_slot  (hit_sl[k]),
      .free_slot (free_sl[k])
    );
  end

  // Verdict: bad header wins over protocol; pass and miss cases report zero.
  always_comb begin
    stored = '0;
    if (op_q) begin
      if (fin.found) begin
        verdict = VERDICT_OVERWRITTEN;
        stored  = fin.perm;
      end else if (fin.free_found) begin
        verdict = VERDICT_INSERTED;
      end else begin
        verdict = VERDICT_TABLE_FULL;
      end
    end else if (hdr_q < MIN_HDR_WORDS) begin
      verdict = VERDICT_PASS_BAD_HDR;
    end else if (proto_q != UDP_PROTO) begin
      verdict = VERDICT_PASS_NON_UDP;
    end else if (!fin.found) begin
      verdict = VERDICT_DENY_NO_ENTRY;
    end else begin
      stored  = fin.perm;
      verdict = (tos_q[7:2] == fin.perm) ? VERDICT_ALLOW : VERDICT_DENY_MISMATCH;
    end
  end

  // Output register: load when free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, stored, verdict};
    end
  end

endmodule

`default_nettype wire

/* src/fptc_checker.sv */
// Port-level checks on the flow table block, bound to its top level.
`default_nettype none

module fptc_checker import fptc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_zero_perm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == VERDICT_PASS_NON_UDP ||
                 m_tdata[2:0] == VERDICT_PASS_BAD_HDR ||
                 m_tdata[2:0] == VERDICT_DENY_NO_ENTRY ||
                 m_tdata[2:0] == VERDICT_INSERTED ||
                 m_tdata[2:0] == VERDICT_TABLE_FULL) |-> m_tdata[8:3] == '0)
    else $error("nonzero permission on a verdict that reports none");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result one cycle after request");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("request taken during clearing pass");

endmodule

bind flow_permission_table_check_core fptc_checker u_fptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the flow permission table check core.
`timescale 1ns / 100ps

module tb;
  import fptc_pkg::*;

  localparam int TBL_SLOTS    = DEF_TABLE_ENTRIES;
  localparam int PROBE_SLOTS  = DEF_PROBE_LIMIT;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 125;

  // One request as the sender sees it, fields at the block's widths.
  typedef struct {
    bit        op;
    bit [3:0]  hdr_words;
    bit [7:0]  protocol;
    bit [7:0]  tos;
    bit [31:0] src_ip;
    bit [31:0] dst_ip;
    bit [15:0] src_port;
    bit [15:0] dst_port;
    bit [5:0]  new_perm;
  } flow_req_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [PERM_W-1:0]    perm;
  } flow_result_t;

  // Mirror of the flow table plus the queue of verdicts still owed by the block.
  class flow_table_scoreboard;
    bit             slot_used[TBL_SLOTS];
    bit [KEY_W-1:0] slot_key[TBL_SLOTS];
    bit [PERM_W-1:0] slot_perm[TBL_SLOTS];
    flow_result_t   verdict_q[$];
    int unsigned    requests;
    int unsigned    results;
    int unsigned    mismatches;
    int unsigned    verdict_seen[8];

    function int unsigned home_of(bit [KEY_W-1:0] key);
      bit [31:0] h;
      h = key[95:64] ^ key[63:32] ^ key[31:0];
      h = h ^ (h >> 16);
      return h % TBL_SLOTS;
    endfunction

    // Walk the probe window: hit is the matching slot, free_slot the first empty one.
    function void probe(input bit [KEY_W-1:0] key, output int hit, output int free_slot);
      int unsigned base;
      int unsigned s;
      base = home_of(key);
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < PROBE_SLOTS; i++) begin
        s = (base + i) % TBL_SLOTS;
        if (slot_used[s]) begin
          if (slot_key[s] == key && hit < 0) hit = s;
        end else if (free_slot < 0 && hit < 0) begin
          free_slot = s;
        end
      end
    endfunction

    function void note_request(flow_req_t r);
      bit [KEY_W-1:0] key;
      int hit;
      int free_slot;
      flow_result_t res;
      key = {r.src_ip, r.dst_ip, r.src_port, r.dst_port};
      res.verdict = VERDICT_PASS_NON_UDP;
      res.perm = '0;
      if (r.op) begin
        probe(key, hit, free_slot);
        if (hit >= 0) begin
          res.perm = slot_perm[hit];
          slot_perm[hit] = r.new_perm;
          res.verdict = VERDICT_OVERWRITTEN;
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot] = key;
          slot_perm[free_slot] = r.new_perm;
          res.verdict = VERDICT_INSERTED;
        end else begin
          res.verdict = VERDICT_TABLE_FULL;
        end
      end else if (r.hdr_words < MIN_HDR_WORDS) begin
        res.verdict = VERDICT_PASS_BAD_HDR;
      end else if (r.protocol != UDP_PROTO) begin
        res.verdict = VERDICT_PASS_NON_UDP;
      end else begin
        probe(key, hit, free_slot);
        if (hit < 0) begin
          res.verdict = VERDICT_DENY_NO_ENTRY;
        end else begin
          res.perm = slot_perm[hit];
          res.verdict = (r.tos[7:2] == slot_perm[hit]) ? VERDICT_ALLOW : VERDICT_DENY_MISMATCH;
        end
      end
      verdict_q.push_back(res);
      requests++;
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch at result %0d: %s", results, what);
      mismatches++;
    endtask

    task check_result(logic [VERDICT_W-1:0] v, logic [PERM_W-1:0] p);
      flow_result_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result with none owed, verdict %0d perm %0d", v, p));
        return;
      end
      want = verdict_q.pop_front();
      results++;
      if (v !== want.verdict)
        report_mismatch($sformatf("verdict %0d, want %0d", v, want.verdict));
      if (p !== want.perm)
        report_mismatch($sformatf("stored_permission %0d, want %0d", p, want.perm));
      if (!$isunknown(v)) verdict_seen[v]++;
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;

  flow_table_scoreboard sb;
  bit [KEY_W-1:0] known_keys[$];   // keys ever sent in an update
  int send_idle_pct;
  int stall_pct;
  int unsigned cycle_count = 0;

  flow_permission_table_check_core #(
    .TABLE_ENTRIES(TBL_SLOTS),
    .PROBE_LIMIT  (PROBE_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run; the limit covers the clearing pass and worst-case stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Pack fields into tdata, lowest field first, zero-filled to 128 bits.
  function automatic logic [127:0] pack_request(flow_req_t r);
    return {6'b0, r.new_perm, r.dst_port, r.src_port, r.dst_ip, r.src_ip,
            r.tos, r.protocol, r.hdr_words};
  endfunction

  function automatic flow_req_t make_request(bit op, bit [3:0] hdr, bit [7:0] proto,
                                             bit [7:0] tos, bit [KEY_W-1:0] key,
                                             bit [5:0] perm);
    flow_req_t r;
    r.op = op;
    r.hdr_words = hdr;
    r.protocol = proto;
    r.tos = tos;
    r.src_ip = key[95:64];
    r.dst_ip = key[63:32];
    r.src_port = key[31:16];
    r.dst_port = key[15:0];
    r.new_perm = perm;
    return r;
  endfunction

  // Present one request, hold it until accepted, then hand it to the scoreboard.
  task automatic send_request(flow_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_request(r);
    s_tuser <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(r);
    if (r.op) known_keys.push_back({r.src_ip, r.dst_ip, r.src_port, r.dst_port});
  endtask

  // Result side: check on every accepted result, then pick the next tready.
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[2:0], m_tdata[8:3]);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Draw a random request. Most are well-formed: updates on new, known or
  // same-home-slot keys, and UDP packets on known flows with a matching DSCP
  // often enough to reach allow. The rest is noise over every field.
  function automatic flow_req_t draw_request();
    flow_req_t r;
    bit [KEY_W-1:0] key;
    int pick;
    int hit;
    int free_slot;
    pick = $urandom_range(99);
    key = {$urandom, $urandom, $urandom};
    r = make_request(1'b0, 4'($urandom_range(15)), 8'($urandom), 8'($urandom), key,
                     6'($urandom));
    if (pick < 35) begin
      r.op = 1'b1;
      if (known_keys.size() > 0 && pick >= 14) begin
        key = known_keys[$urandom_range(known_keys.size() - 1)];
        // flip source byte 1 only: same home slot, new flow, crowds the window
        if (pick >= 26) key[79:72] = key[79:72] ^ 8'($urandom_range(1, 255));
      end
    end else if (pick < 80) begin
      r.hdr_words = 4'($urandom_range(5, 15));
      r.protocol = UDP_PROTO;
      if (known_keys.size() > 0 && $urandom_range(99) < 80)
        key = known_keys[$urandom_range(known_keys.size() - 1)];
      sb.probe(key, hit, free_slot);
      if (hit >= 0 && $urandom_range(99) < 60)
        r.tos = {sb.slot_perm[hit], 2'($urandom)};
    end else begin
      r.op = 1'($urandom);
      if ($urandom_range(3) == 0) r.protocol = UDP_PROTO;
      if (known_keys.size() > 0 && $urandom_range(1) == 1)
        key = known_keys[$urandom_range(known_keys.size() - 1)];
    end
    r.src_ip = key[95:64];
    r.dst_ip = key[63:32];
    r.src_port = key[31:16];
    r.dst_port = key[15:0];
    return r;
  endfunction

  initial begin
    bit [KEY_W-1:0] key_zero;
    bit [KEY_W-1:0] key_ones;
    bit [KEY_W-1:0] key_crowd;
    bit [KEY_W-1:0] key_wrap;
    key_zero = '0;
    key_ones = '1;
    key_crowd = {32'h1234_0056, 32'h0, 16'h0, 16'h0};   // home slot 0x62
    key_wrap = {32'h0000_00ff, 32'h0, 16'h0, 16'h0};    // home slot 0xff
    sb = new();
    send_idle_pct = 36;
    stall_pct = 75;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Pass paths: a short header wins even over UDP; new_permission is ignored.
    send_request(make_request(1'b0, 4'd0, UDP_PROTO, 8'hff, key_ones, 6'h3f));
    send_request(make_request(1'b0, 4'd4, 8'd6, 8'h00, key_zero, 6'h00));
    send_request(make_request(1'b0, 4'd15, 8'd0, 8'h55, key_zero, 6'h2a));
    send_request(make_request(1'b0, 4'd5, 8'd255, 8'haa, key_ones, 6'h15));
    // Missing flow drops; then insert the all-zero and all-one keys.
    send_request(make_request(1'b0, 4'd5, UDP_PROTO, 8'h00, key_zero, 6'h3f));
    send_request(make_request(1'b1, 4'd0, 8'd0, 8'hff, key_zero, 6'd0));
    send_request(make_request(1'b1, 4'd15, 8'd255, 8'h00, key_ones, 6'd63));
    // Allow with tos low bits set, mismatch, overwrite returning the old value.
    send_request(make_request(1'b0, 4'd15, UDP_PROTO, 8'hff, key_ones, 6'd0));
    send_request(make_request(1'b0, 4'd5, UDP_PROTO, 8'h00, key_ones, 6'd0));
    send_request(make_request(1'b0, 4'd9, UDP_PROTO, 8'h03, key_zero, 6'd0));
    send_request(make_request(1'b1, 4'd7, 8'd17, 8'h12, key_ones, 6'd21));
    send_request(make_request(1'b0, 4'd5, UDP_PROTO, 8'd84, key_ones, 6'd0));
    // Fill one probe window with keys sharing a home slot; the ninth finds it full.
    for (int k = 0; k < PROBE_SLOTS + 1; k++) begin
      key_crowd[79:72] = 8'(k);
      send_request(make_request(1'b1, 4'd0, 8'd0, 8'd0, key_crowd, 6'(k * 7)));
    end
    send_request(make_request(1'b0, 4'd5, UDP_PROTO, 8'h00, key_crowd, 6'd0));
    key_crowd[79:72] = 8'd3;
    send_request(make_request(1'b1, 4'd0, 8'd0, 8'd0, key_crowd, 6'd9));
    // Window starting at the last slot wraps around to the bottom of the table.
    send_request(make_request(1'b1, 4'd0, 8'd0, 8'd0, key_wrap, 6'd33));
    key_wrap[79:72] = 8'h01;
    send_request(make_request(1'b1, 4'd0, 8'd0, 8'd0, key_wrap, 6'd44));
    send_request(make_request(1'b0, 4'd5, UDP_PROTO, 8'd176, key_wrap, 6'd0));

    // Random traffic over three idling profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 75 : 0;
      stall_pct = (phase == 0) ? 75 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) send_request(draw_request());
    end
    s_tvalid <= 1'b0;

    // Drain, then give the block time to emit anything it should not.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests, %0d results checked, %0d flows keyed, %0d mismatches",
             sb.requests, sb.results, known_keys.size(), sb.mismatches);
    $display("tb: verdict mix 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.verdict_seen[0], sb.verdict_seen[1], sb.verdict_seen[2], sb.verdict_seen[3],
             sb.verdict_seen[4], sb.verdict_seen[5], sb.verdict_seen[6], sb.verdict_seen[7]);
    if (sb.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
